// File: sv/tcf_pkg.sv
// tcf_pkg: constants, types and the cordic arctangent table of the tilt filter
// used by every module of the tilt complementary filter core; no dependencies
package tcf_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_FRAC_BITS   = 8;

  localparam int Z_FRAC    = 24;
  localparam int TABLE_LEN = 24;
  localparam int TAB_IDX_W = $clog2(TABLE_LEN);
  localparam int ITER_W    = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

  localparam int SAMPLE_W  = 16;
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int XY_W   = 19;
  localparam int Z_W    = 33;
  localparam int ATAN_W = 30;

  localparam int TILT_W     = 10 + ANGLE_FRAC_BITS;
  localparam int PRED_SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
  localparam int PRED_W     = 35;
  localparam int OP_W       = 18;
  localparam int PROD_W     = 2 * OP_W;
  localparam int SPLIT      = 17;
  localparam int MIX_W      = 54;
  localparam int MIX_SHIFT  = 16 + Z_FRAC - ANGLE_FRAC_BITS;
  localparam int R_W        = MIX_W - MIX_SHIFT;

  localparam int DEG_W     = 10;
  localparam int FINE_W    = 18;
  localparam int S_TDATA_W = 3 * SAMPLE_W;
  localparam int M_TDATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_COEF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE = 1'b1;

  localparam logic [REG_W-1:0] BLEND_RESET = 16'd64225;
  localparam logic [REG_W-1:0] SCALE_RESET = 16'd2561;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL_GY,
    ST_PRED,
    ST_MUL_PH,
    ST_MUL_PL,
    ST_MUL_AH,
    ST_MUL_AL,
    ST_ADD_LAST,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_GY,
    MUL_PRED_HI,
    MUL_PRED_LO,
    MUL_TILT_HI,
    MUL_TILT_LO
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_SHIFT,
    ACC_PLAIN
  } acc_op_e;

  typedef struct packed {
    logic     load;
    logic     iter;
    logic     pred_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     out_en;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_last;
  } dp_status_t;

  // atan(2^-i) in degrees, q.24, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/tcf_ctrl.sv
// tcf_ctrl: sequencing state machine of the tilt filter, output valid flag
// depends on tcf_pkg; drives tcf_datapath through dp_cmd_t
module tcf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output tcf_pkg::dp_cmd_t    cmd_o,
  input  tcf_pkg::dp_status_t status_i
);
  import tcf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_valid_i) state_d = ST_CORDIC;
      ST_CORDIC:   if (status_i.iter_last) state_d = ST_MUL_GY;
      ST_MUL_GY:   state_d = ST_PRED;
      ST_PRED:     state_d = ST_MUL_PH;
      ST_MUL_PH:   state_d = ST_MUL_PL;
      ST_MUL_PL:   state_d = ST_MUL_AH;
      ST_MUL_AH:   state_d = ST_MUL_AL;
      ST_MUL_AL:   state_d = ST_ADD_LAST;
      ST_ADD_LAST: state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o     = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.iter    = 1'b0;
    cmd_o.pred_en = 1'b0;
    cmd_o.mul_sel = MUL_GY;
    cmd_o.acc_op  = ACC_HOLD;
    cmd_o.out_en  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load   = 1'b1;
          cmd_o.acc_op = ACC_INIT;
        end
      end
      ST_CORDIC: cmd_o.iter = 1'b1;
      ST_MUL_GY: cmd_o.mul_sel = MUL_GY;
      ST_PRED:   cmd_o.pred_en = 1'b1;
      ST_MUL_PH: cmd_o.mul_sel = MUL_PRED_HI;
      ST_MUL_PL: begin
        cmd_o.mul_sel = MUL_PRED_LO;
        cmd_o.acc_op  = ACC_SHIFT;
      end
      ST_MUL_AH: begin
        cmd_o.mul_sel = MUL_TILT_HI;
        cmd_o.acc_op  = ACC_PLAIN;
      end
      ST_MUL_AL: begin
        cmd_o.mul_sel = MUL_TILT_LO;
        cmd_o.acc_op  = ACC_SHIFT;
      end
      ST_ADD_LAST: cmd_o.acc_op = ACC_PLAIN;
      ST_DONE:     cmd_o.out_en = out_free;
      default:     s_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_en) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// File: sv/tcf_datapath.sv
// tcf_datapath: cordic arctangent, shared 18x18 multiplier, mix accumulator,
// kept angle, config registers and output register; depends on tcf_pkg
module tcf_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcf_pkg::REG_W-1:0]         cfg_data_i,
  input  logic [tcf_pkg::S_TDATA_W-1:0]     s_data_i,
  input  tcf_pkg::dp_cmd_t                  cmd_i,
  output tcf_pkg::dp_status_t               status_o,
  output logic signed [tcf_pkg::DEG_W-1:0]  tilt_deg_o,
  output logic signed [tcf_pkg::FINE_W-1:0] tilt_fine_o
);
  import tcf_pkg::*;

  localparam logic signed [Z_W-1:0] Z_90 = Z_W'(64'd90 << Z_FRAC);
  localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(64'd1 << (MIX_SHIFT - 1));
  localparam logic signed [R_W-1:0] R_HI = R_W'((64'd1 << (TILT_W - 1)) - 64'd1);
  localparam logic signed [R_W-1:0] R_LO = -R_W'(64'd1 << (TILT_W - 1));
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

  logic [REG_W-1:0]          blend_q, scale_q;
  logic signed [TILT_W-1:0]  tilt_q;
  logic [ITER_W-1:0]         iter_q;

  logic signed [XY_W-1:0]    x_q, y_q, x_d, y_d, xs, ys;
  logic signed [Z_W-1:0]     z_q, z_d, atan_s, acc_tilt;
  logic                      zero_q;
  logic signed [SAMPLE_W-1:0] gy_q;
  logic signed [PRED_W-1:0]  pred_q;
  logic signed [OP_W-1:0]    opa, opb;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [MIX_W-1:0]   mix_q;
  logic signed [R_W-1:0]     r;
  logic signed [TILT_W-1:0]  sat, deg_full;
  logic [SPLIT-1:0]          accel_w;
  logic signed [SAMPLE_W-1:0] ax, az;
  logic signed [DEG_W-1:0]   deg_q;
  logic signed [FINE_W-1:0]  fine_q;

  assign ax = $signed(s_data_i[SAMPLE_W-1:0]);
  assign az = $signed(s_data_i[2*SAMPLE_W-1:SAMPLE_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= BLEND_RESET;
      scale_q <= SCALE_RESET;
      tilt_q  <= '0;
      iter_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_BLEND_COEF) blend_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_GYRO_SCALE) scale_q <= cfg_data_i;
      if (cmd_i.out_en) tilt_q <= sat;
      if (cmd_i.load) begin
        iter_q <= '0;
      end else if (cmd_i.iter) begin
        iter_q <= iter_q + ITER_W'(1);
      end
    end
  end

  assign status_o.iter_last = (iter_q == ITER_LAST);

  // cordic step, vectoring toward y = 0
  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign atan_s = $signed(Z_W'(atan_q24(TAB_IDX_W'(iter_q))));

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (cmd_i.load) begin
      if (az < 0) begin
        if (ax >= 0) begin
          x_d = XY_W'(ax);
          y_d = -XY_W'(az);
          z_d = Z_90;
        end else begin
          x_d = -XY_W'(ax);
          y_d = XY_W'(az);
          z_d = -Z_90;
        end
      end else begin
        x_d = XY_W'(az);
        y_d = XY_W'(ax);
        z_d = '0;
      end
    end else if (cmd_i.iter) begin
      if (!y_q[XY_W-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_s;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_s;
      end
    end
  end

  assign acc_tilt = zero_q ? '0 : z_q;
  assign accel_w  = SPLIT'(18'h10000 - {2'b00, blend_q});

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.mul_sel)
      MUL_GY: begin
        opa = OP_W'(gy_q);
        opb = $signed({2'b00, scale_q});
      end
      MUL_PRED_HI: begin
        opa = pred_q[PRED_W-1:SPLIT];
        opb = $signed({2'b00, blend_q});
      end
      MUL_PRED_LO: begin
        opa = $signed({1'b0, pred_q[SPLIT-1:0]});
        opb = $signed({2'b00, blend_q});
      end
      MUL_TILT_HI: begin
        opa = OP_W'($signed(acc_tilt[Z_W-1:SPLIT]));
        opb = $signed({1'b0, accel_w});
      end
      MUL_TILT_LO: begin
        opa = $signed({1'b0, acc_tilt[SPLIT-1:0]});
        opb = $signed({1'b0, accel_w});
      end
      default: opa = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    prod_q <= opa * opb;
    if (cmd_i.load) begin
      zero_q <= (ax == 0) && (az == 0);
      gy_q   <= $signed(s_data_i[3*SAMPLE_W-1:2*SAMPLE_W]);
    end
    if (cmd_i.pred_en) begin
      pred_q <= (PRED_W'(tilt_q) <<< PRED_SHIFT) - PRED_W'(prod_q);
    end
    case (cmd_i.acc_op)
      ACC_INIT:  mix_q <= MIX_HALF;
      ACC_SHIFT: mix_q <= mix_q + (MIX_W'(prod_q) <<< SPLIT);
      ACC_PLAIN: mix_q <= mix_q + MIX_W'(prod_q);
      default:   mix_q <= mix_q;
    endcase
    if (cmd_i.out_en) begin
      deg_q  <= DEG_W'(deg_full);
      fine_q <= FINE_W'(sat);
    end
  end

  // round half up already folded into the accumulator start value
  assign r = mix_q[MIX_W-1:MIX_SHIFT];

  always_comb begin
    if (r > R_HI) begin
      sat = TILT_W'(R_HI);
    end else if (r < R_LO) begin
      sat = TILT_W'(R_LO);
    end else begin
      sat = TILT_W'(r);
    end
  end

  // integer degrees, truncated toward zero
  assign deg_full = (sat >>> ANGLE_FRAC_BITS)
                  + TILT_W'(sat[TILT_W-1] && (|sat[ANGLE_FRAC_BITS-1:0]));

  assign tilt_deg_o  = deg_q;
  assign tilt_fine_o = fine_q;

endmodule

// File: sv/tilt_complementary_filter_core.sv
// tilt complementary filter core: accel tilt by cordic, blended with gyro step
// samples are processed one at a time: a new one is accepted only in idle,
// once the previous result is stored; pacing is set by the one-step-per-cycle
// cordic and the shared multiplier, and is slower while the output stalls
// reset: async active low, clears kept angle and sequencer, config to defaults
module tilt_complementary_filter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcf_pkg::REG_W-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tcf_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // accel_x, accel_z, gyro_y
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tcf_pkg::M_TDATA_W-1:0]     m_axis_tdata   // tilt_deg, tilt_fine, zero pad
);
  import tcf_pkg::*;

  dp_cmd_t                  cmd;
  dp_status_t               status;
  logic signed [DEG_W-1:0]  tilt_deg;
  logic signed [FINE_W-1:0] tilt_fine;

  tcf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  tcf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_data_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .tilt_deg_o  (tilt_deg),
    .tilt_fine_o (tilt_fine)
  );

  assign m_axis_tdata = {{(M_TDATA_W - DEG_W - FINE_W){1'b0}}, tilt_fine, tilt_deg};

endmodule

// File: sv/tcf_checker.sv
// tcf_checker: port-level assertions for the tilt filter core, bound to it
// depends on tcf_pkg and tilt_complementary_filter_core
module tcf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tcf_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import tcf_pkg::*;

  logic                     s_hs, m_hs;
  logic [1:0]               pend_q;
  logic signed [FINE_W-1:0] fine;
  logic signed [FINE_W-1:0] deg_exp;

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;
  assign fine = $signed(m_axis_tdata[DEG_W+FINE_W-1:DEG_W]);
  assign deg_exp = (fine >>> ANGLE_FRAC_BITS)
                 + FINE_W'(fine[FINE_W-1] && (|fine[ANGLE_FRAC_BITS-1:0]));

  // samples accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(s_hs) - 2'(m_hs);
    end
  end

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !s_axis_tready)
    else $error("input accepted while a sample is in progress");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without an accepted sample");

  a_deg_matches_fine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DEG_W-1:0] == deg_exp[DEG_W-1:0])
    else $error("whole degrees disagree with fine angle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind tilt_complementary_filter_core tcf_checker u_tcf_checker (.*);

// File: dv/tb_top.sv
// tb_top: self-checking testbench of tilt_complementary_filter_core
// a directed table and random samples are checked against a bit-true tilt predictor
// depends on tcf_pkg and tilt_complementary_filter_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcf_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 100;

  localparam longint ATAN_DEG_Q24 [0:23] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef struct packed {
    logic signed [DEG_W-1:0]  deg;
    logic signed [FINE_W-1:0] fine;
  } tilt_result_t;

  typedef struct {
    logic [REG_W-1:0]           blend;
    logic [REG_W-1:0]           scale;
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] az;
    logic signed [SAMPLE_W-1:0] gy;
    bit                         typed;
    int                         deg;
    int                         fine;
  } sample_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = CFG_BLEND_COEF;
  logic [REG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // accel_x, accel_z, gyro_y
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;        // tilt_deg, tilt_fine, zero pad

  tilt_result_t  tilt_expected [$];
  sample_row_t   directed_rows [$];

  logic [REG_W-1:0] mdl_blend = BLEND_RESET;
  logic [REG_W-1:0] mdl_scale = SCALE_RESET;
  longint           kept_angle = 0;

  int  fail_count     = 0;
  int  results_seen   = 0;
  int  samples_sent   = 0;
  int  settings_count = 0;
  int  cycle_count    = 0;
  int  stall_left     = 0;
  bit  in_calm        = 1'b0;
  bit  out_calm       = 1'b0;

  tilt_complementary_filter_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // vectoring cordic, degrees in q.24
  function automatic longint cordic_atan2_deg(input longint num, input longint den);
    longint x, y, z, t, xs, ys;
    int     i;
    x = den;
    y = num;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        z = longint'(90) <<< Z_FRAC;
      end else begin
        t = x; x = -y; y = t;
        z = -(longint'(90) <<< Z_FRAC);
      end
    end
    for (i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_DEG_Q24[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_DEG_Q24[i];
      end
    end
    return z;
  endfunction

  function automatic tilt_result_t advance_tilt(input logic signed [SAMPLE_W-1:0] ax,
                                                input logic signed [SAMPLE_W-1:0] az,
                                                input logic signed [SAMPLE_W-1:0] gy);
    longint       acc, a, sc, pred, mix, r, hi, lo;
    int           sh;
    tilt_result_t res;
    sh   = 16 + Z_FRAC - ANGLE_FRAC_BITS;
    hi   = (longint'(512) <<< ANGLE_FRAC_BITS) - 1;
    lo   = -(longint'(512) <<< ANGLE_FRAC_BITS);
    acc  = cordic_atan2_deg(longint'(ax), longint'(az));
    a    = longint'({48'd0, mdl_blend});
    sc   = longint'({48'd0, mdl_scale});
    pred = kept_angle * (longint'(1) <<< (Z_FRAC - ANGLE_FRAC_BITS)) - longint'(gy) * sc;
    mix  = a * pred + (longint'(65536) - a) * acc;
    r    = (mix + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    kept_angle = r;
    res.deg    = DEG_W'(r / (longint'(1) <<< ANGLE_FRAC_BITS));
    res.fine   = FINE_W'(r);
    return res;
  endfunction

  function automatic int idle_len(input bit calm);
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(5, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return 16'sd1;
      2: return -16'sd1;
      3: return 16'sh7fff;
      4: return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void add_row(input int blend, input int scale, input int ax, input int az,
                                  input int gy, input bit typed, input int deg, input int fine);
    sample_row_t row;
    row.blend = REG_W'(blend);
    row.scale = REG_W'(scale);
    row.ax    = SAMPLE_W'(ax);
    row.az    = SAMPLE_W'(az);
    row.gy    = SAMPLE_W'(gy);
    row.typed = typed;
    row.deg   = deg;
    row.fine  = fine;
    directed_rows.push_back(row);
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tilt_expected.size() != 0);
  endtask

  task automatic program_coefs(input logic [REG_W-1:0] blend, input logic [REG_W-1:0] scale);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BLEND_COEF;
    cfg_data_i <= blend;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GYRO_SCALE;
    cfg_data_i <= scale;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mdl_blend  = blend;
    mdl_scale  = scale;
    settings_count++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                             input logic signed [SAMPLE_W-1:0] az,
                             input logic signed [SAMPLE_W-1:0] gy,
                             input bit typed, input int deg, input int fine);
    int           gap;
    tilt_result_t want;
    gap = idle_len(in_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gy, az, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    want = advance_tilt(ax, az, gy);
    if (typed) begin
      want.deg  = DEG_W'(deg);
      want.fine = FINE_W'(fine);
    end
    tilt_expected.push_back(want);
    samples_sent++;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               tilt_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    tilt_result_t             want;
    logic signed [DEG_W-1:0]  got_deg;
    logic signed [FINE_W-1:0] got_fine;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_deg  = m_axis_tdata[DEG_W-1:0];
      got_fine = m_axis_tdata[DEG_W +: FINE_W];
      results_seen++;
      if (tilt_expected.size() == 0) begin
        $error("unexpected output transaction: tilt_deg %0d, tilt_fine %0d", got_deg, got_fine);
        fail_count++;
      end else begin
        want = tilt_expected.pop_front();
        if (got_deg !== want.deg) begin
          $error("tilt_deg mismatch: expected %0d, actual %0d", want.deg, got_deg);
          fail_count++;
        end
        if (got_fine !== want.fine) begin
          $error("tilt_fine mismatch: expected %0d, actual %0d", want.fine, got_fine);
          fail_count++;
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!out_calm && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int               ph, n, p, directed_count;
    logic [REG_W-1:0] blend, scale;
    logic signed [SAMPLE_W-1:0] ax, az, gy;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default coefficients: quadrant handling and extremes
    add_row(BLEND_RESET, SCALE_RESET,      0,      0,      0, 1, 0, 0);
    add_row(BLEND_RESET, SCALE_RESET,  32767,  32767,      0, 0, 0, 0);
    add_row(BLEND_RESET, SCALE_RESET,      0, -32768,      0, 0, 0, 0);
    add_row(BLEND_RESET, SCALE_RESET, -32768, -32768,  32767, 0, 0, 0);
    add_row(BLEND_RESET, SCALE_RESET,  32767,     -1, -32768, 0, 0, 0);
    add_row(BLEND_RESET, SCALE_RESET, -32768,      0,      1, 0, 0, 0);
    add_row(BLEND_RESET, SCALE_RESET,      1,      0,     -1, 0, 0, 0);
    // zero blend: accel tilt only
    add_row(0, SCALE_RESET,      0,      0,  12345, 1, 0, 0);
    add_row(0, SCALE_RESET,      0,    100,      0, 0, 0, 0);
    add_row(0, SCALE_RESET, -32768,  32767, -32768, 0, 0, 0);
    add_row(0, SCALE_RESET,      0,     -1,      0, 0, 0, 0);
    // full gyro weight and gain: drive into both saturation limits
    for (n = 0; n < 5; n++)
      add_row(65535, 65535, 0, 0, -32768, n >= 3, 511, 131071);
    for (n = 0; n < 9; n++)
      add_row(65535, 65535, 0, 0, 32767, n == 8, -512, -131072);
    directed_count = directed_rows.size();

    foreach (directed_rows[i]) begin
      if (directed_rows[i].blend != mdl_blend || directed_rows[i].scale != mdl_scale) begin
        if (samples_sent > 0) wait_drained();
        program_coefs(directed_rows[i].blend, directed_rows[i].scale);
      end
      send_sample(directed_rows[i].ax, directed_rows[i].az, directed_rows[i].gy,
                  directed_rows[i].typed, directed_rows[i].deg, directed_rows[i].fine);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin blend = BLEND_RESET; scale = SCALE_RESET; end
        1: begin blend = '0; scale = REG_W'($urandom); end
        2: begin blend = '1; scale = '0; end
        3: begin blend = REG_W'($urandom); scale = '1; end
        5: begin blend = '1; scale = REG_W'($urandom_range(0, 4000)); end
        6: begin blend = REG_W'($urandom_range(60000, 65535)); scale = REG_W'($urandom); end
        7: begin blend = BLEND_RESET; scale = REG_W'($urandom_range(0, 8000)); end
        default: begin blend = REG_W'($urandom); scale = REG_W'($urandom); end
      endcase
      wait_drained();
      program_coefs(blend, scale);
      in_calm  = (ph == 3);
      out_calm = (ph == 3 || ph == 5);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        p = $urandom_range(0, 9);
        if (p < 5) begin
          ax = SAMPLE_W'($urandom);
          az = SAMPLE_W'($urandom);
          gy = SAMPLE_W'($urandom);
        end else if (p < 8) begin
          ax = SAMPLE_W'(int'($urandom_range(0, 32768)) - 16384);
          az = SAMPLE_W'(int'($urandom_range(0, 32768)) - 16384);
          gy = SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
        end else begin
          ax = corner_value();
          az = corner_value();
          gy = corner_value();
        end
        send_sample(ax, az, gy, 1'b0, 0, 0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d imu samples (%0d from the directed table) over %0d coefficient settings",
             samples_sent, directed_count, settings_count);
    $display("checked %0d tilt results, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && tilt_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/tcf_pkg.sv
sv/tcf_ctrl.sv
sv/tcf_datapath.sv
sv/tilt_complementary_filter_core.sv
sv/tcf_checker.sv
dv/tb_top.sv
